// ===== rtl/hjb_pkg.sv =====
`default_nettype none

package hjb_pkg;

   // Field widths of the request, response and register words
   localparam int CMD_W       = 3;
   localparam int ADC_W       = 10;
   localparam int TICK_W      = 16;
   localparam int KIND_W      = 2;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;

   // Canned report sequences are at most three words long
   localparam int SCRIPT_DEPTH = 3;
   localparam int SCRIPT_W     = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT     = 3'd0,
      CMD_REMOVE     = 3'd1,
      CMD_PRESS      = 3'd2,
      CMD_RELEASE    = 3'd3,
      CMD_MIC_SAMPLE = 3'd4,
      CMD_TICK       = 3'd5
   } cmd_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_HEADPHONE = 2'd0,
      KIND_MIC       = 2'd1,
      KIND_KEY       = 2'd2,
      KIND_PROBE     = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_EMIT,
      ST_DISP_READ,
      ST_DISP_SEND
   } state_type;

   typedef struct packed {
      kind_type kind;
      logic     value;
   } report_type;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_MIC_THRESHOLD  = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE_TICKS = 4'd1;

   // Register reset values
   localparam logic [ADC_W-1:0]  MIC_THRESHOLD_RESET  = 10'd80;
   localparam logic [TICK_W-1:0] DEBOUNCE_TICKS_RESET = 16'd100;

endpackage

`default_nettype wire

// ===== rtl/hjb_req_if.sv =====
`default_nettype none

interface hjb_req_if
   import hjb_pkg::*;
   ;
   logic             valid;
   logic             ready;
   logic [CMD_W-1:0] cmd;
   logic [ADC_W-1:0] adc_value;

   modport source (output valid, output cmd, output adc_value, input ready);
   modport sink (input valid, input cmd, input adc_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/hjb_rsp_if.sv =====
`default_nettype none

interface hjb_rsp_if
   import hjb_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] report_kind;
   logic              report_value;
   logic              last;

   modport source (output valid, output report_kind, output report_value, output last,
                   input ready);
   modport sink (input valid, input report_kind, input report_value, input last,
                 output ready);
endinterface

`default_nettype wire

// ===== rtl/hjb_csr_if.sv =====
`default_nettype none

interface hjb_csr_if
   import hjb_pkg::*;
   ;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/hjb_ram.sv =====
`default_nettype none

module hjb_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, register the read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/headset_jack_button_controller.sv =====
// Headset jack and button controller.
// req_ch takes one command word (insert, remove, press, release, mic sample,
// tick) with an ADC reading; rsp_ch returns the report words it causes, the
// final one of each command flagged by last. csr_ch writes mic_threshold
// (index 0) and debounce_ticks (index 1); it is always ready and must only be
// used while the block is idle.
// Timing: a command is accepted in IDLE and decoded in the next cycle by a
// small sequencer around one shared magnitude comparator (ADC against
// threshold, or countdown against one). A command without reports returns
// to IDLE from EXEC. Canned reports (insert, remove, mic sample) leave one
// per cycle while the receiver does not stall, registered in EMIT after EXEC.
// A debounce dispatch reads the button queue RAM through its registered
// read port, alternating DISP_READ and DISP_SEND for each key report.
// req_ch.ready is high only in IDLE; an output register holds the response
// word, so a stalled receiver freezes the sequencer with the word held.
// Reset clears the jack, mic, button and countdown state, empties the queue
// and restores the registers to 80 and 100. Queue RAM contents are not
// cleared; entries are only read below the fill count.
`default_nettype none

module headset_jack_button_controller
   import hjb_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   hjb_req_if.sink    req_ch,
   hjb_rsp_if.source  rsp_ch,
   hjb_csr_if.sink    csr_ch
);

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   state_type            state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic [ADC_W-1:0]     adc_ff, adc_in;
   logic [ADC_W-1:0]     mic_threshold_ff, mic_threshold_in;
   logic [TICK_W-1:0]    debounce_ff, debounce_in;
   logic                 headset_in_ff, headset_in_in;
   logic                 mic_found_ff, mic_found_in;
   logic                 button_down_ff, button_down_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [TICK_W-1:0]    countdown_ff, countdown_in;
   logic                 armed_ff, armed_in;
   report_type           script_ff [SCRIPT_DEPTH];
   report_type           script_in [SCRIPT_DEPTH];
   logic [SCRIPT_W-1:0]  script_len_ff, script_len_in;
   logic [SCRIPT_W-1:0]  script_idx_ff, script_idx_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   report_type           rsp_report_ff, rsp_report_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 req_accept;
   logic                 out_free;
   logic [TICK_W-1:0]    cmp_a, cmp_b;
   logic                 cmp_gt;
   logic                 is_button;
   logic                 button_ok;
   logic                 fire;
   logic                 go_emit;
   logic                 go_disp;
   logic                 script_last;
   logic                 key_last;
   logic                 ram_we;
   logic                 ram_rd_data;

   assign req_accept = req_ch.valid && req_ch.ready;
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;

   // Share one comparator between the mic probe and the countdown check
   always_comb begin
      if (cmd_ff == CMD_MIC_SAMPLE) begin
         cmp_a = {{(TICK_W-ADC_W){1'b0}}, adc_ff};
         cmp_b = {{(TICK_W-ADC_W){1'b0}}, mic_threshold_ff};
      end else begin
         cmp_a = countdown_ff;
         cmp_b = TICK_W'(1);
      end
      cmp_gt = cmp_a > cmp_b;
   end

   // Decode the held command
   always_comb begin
      is_button = (cmd_ff == CMD_PRESS) || (cmd_ff == CMD_RELEASE);
      button_ok = is_button && mic_found_ff && (count_ff != CNT_W'(QUEUE_DEPTH))
                  && (button_down_ff != (cmd_ff == CMD_PRESS));
      fire      = (cmd_ff == CMD_TICK) && armed_ff && !cmp_gt;
      go_emit   = (cmd_ff == CMD_INSERT) || (cmd_ff == CMD_REMOVE)
                  || (cmd_ff == CMD_MIC_SAMPLE);
      go_disp   = fire && headset_in_ff && mic_found_ff && (count_ff != '0);
      script_last = (script_idx_ff + SCRIPT_W'(1)) == script_len_ff;
      key_last    = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (go_disp) state_in = ST_DISP_READ;
            else if (go_emit) state_in = ST_EMIT;
            else state_in = ST_IDLE;
         end
         ST_EMIT: begin
            if (out_free && script_last) state_in = ST_IDLE;
         end
         ST_DISP_READ: begin
            state_in = ST_DISP_SEND;
         end
         ST_DISP_SEND: begin
            if (out_free) state_in = key_last ? ST_IDLE : ST_DISP_READ;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Handshake and queue write outputs
   always_comb begin
      req_ch.ready = (state_ff == ST_IDLE);
      csr_ch.ready = 1'b1;
      ram_we       = (state_ff == ST_EXEC) && button_ok;
   end

   // Datapath
   always_comb begin
      cmd_in           = cmd_ff;
      adc_in           = adc_ff;
      mic_threshold_in = mic_threshold_ff;
      debounce_in      = debounce_ff;
      headset_in_in    = headset_in_ff;
      mic_found_in     = mic_found_ff;
      button_down_in   = button_down_ff;
      count_in         = count_ff;
      countdown_in     = countdown_ff;
      armed_in         = armed_ff;
      script_in        = script_ff;
      script_len_in    = script_len_ff;
      script_idx_in    = script_idx_ff;
      idx_in           = idx_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ch.ready;
      rsp_report_in    = rsp_report_ff;
      rsp_last_in      = rsp_last_ff;

      // Take register writes
      if (csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.index)
            CSR_MIC_THRESHOLD:  mic_threshold_in = csr_ch.data[ADC_W-1:0];
            CSR_DEBOUNCE_TICKS: debounce_in = csr_ch.data[TICK_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cmd_in = cmd_type'(req_ch.cmd);
               adc_in = req_ch.adc_value;
            end
         end
         ST_EXEC: begin
            script_idx_in = '0;
            case (cmd_ff)
               CMD_INSERT: begin
                  script_in[0]  = '{kind: KIND_HEADPHONE, value: 1'b1};
                  script_len_in = SCRIPT_W'(1);
                  headset_in_in = 1'b1;
                  mic_found_in  = 1'b0;
               end
               CMD_REMOVE: begin
                  if (mic_found_ff) begin
                     armed_in = 1'b0;
                     if (button_down_ff) begin
                        script_in[0]  = '{kind: KIND_KEY, value: 1'b0};
                        script_in[1]  = '{kind: KIND_MIC, value: 1'b0};
                        script_len_in = SCRIPT_W'(2);
                     end else begin
                        script_in[0]  = '{kind: KIND_MIC, value: 1'b0};
                        script_len_in = SCRIPT_W'(1);
                     end
                  end else begin
                     script_in[0]  = '{kind: KIND_HEADPHONE, value: 1'b0};
                     script_len_in = SCRIPT_W'(1);
                  end
                  headset_in_in  = 1'b0;
                  mic_found_in   = 1'b0;
                  button_down_in = 1'b0;
                  count_in       = '0;
               end
               CMD_PRESS, CMD_RELEASE: begin
                  if (button_ok) begin
                     button_down_in = (cmd_ff == CMD_PRESS);
                     count_in       = count_ff + CNT_W'(1);
                     countdown_in   = debounce_ff;
                     armed_in       = 1'b1;
                  end
               end
               CMD_MIC_SAMPLE: begin
                  if (cmp_gt || !headset_in_ff) begin
                     mic_found_in  = 1'b0;
                     script_in[0]  = '{kind: KIND_PROBE, value: 1'b0};
                     script_len_in = SCRIPT_W'(1);
                  end else begin
                     mic_found_in  = 1'b1;
                     script_in[0]  = '{kind: KIND_MIC, value: 1'b1};
                     script_in[1]  = '{kind: KIND_HEADPHONE, value: 1'b0};
                     script_in[2]  = '{kind: KIND_PROBE, value: 1'b1};
                     script_len_in = SCRIPT_W'(3);
                  end
               end
               CMD_TICK: begin
                  if (armed_ff) begin
                     if (fire) begin
                        armed_in = 1'b0;
                        idx_in   = '0;
                        // Drop the queue when no headset mic is there
                        if (!(headset_in_ff && mic_found_ff)) begin
                           count_in       = '0;
                           button_down_in = 1'b0;
                        end
                     end else begin
                        countdown_in = countdown_ff - TICK_W'(1);
                     end
                  end
               end
               default: ;
            endcase
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_report_in = script_ff[script_idx_ff];
               rsp_last_in   = script_last;
               script_idx_in = script_idx_ff + SCRIPT_W'(1);
            end
         end
         ST_DISP_SEND: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_report_in = '{kind: KIND_KEY, value: ram_rd_data};
               rsp_last_in   = key_last;
               if (key_last) count_in = '0;
               else idx_in = idx_ff + IDX_W'(1);
            end
         end
         default: ;
      endcase
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         mic_threshold_ff <= MIC_THRESHOLD_RESET;
         debounce_ff      <= DEBOUNCE_TICKS_RESET;
         headset_in_ff    <= 1'b0;
         mic_found_ff     <= 1'b0;
         button_down_ff   <= 1'b0;
         count_ff         <= '0;
         countdown_ff     <= '0;
         armed_ff         <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         mic_threshold_ff <= mic_threshold_in;
         debounce_ff      <= debounce_in;
         headset_in_ff    <= headset_in_in;
         mic_found_ff     <= mic_found_in;
         button_down_ff   <= button_down_in;
         count_ff         <= count_in;
         countdown_ff     <= countdown_in;
         armed_ff         <= armed_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      adc_ff        <= adc_in;
      script_ff     <= script_in;
      script_len_ff <= script_len_in;
      script_idx_ff <= script_idx_in;
      idx_ff        <= idx_in;
      rsp_report_ff <= rsp_report_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Button event queue
   hjb_ram #(
      .WIDTH (1),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (cmd_ff == CMD_PRESS),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   // Drive the response word
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.report_kind  = rsp_report_ff.kind;
   assign rsp_ch.report_value = rsp_report_ff.value;
   assign rsp_ch.last         = rsp_last_ff;

   // Fill count never passes the queue depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count above depth");

   // Dispatch only runs over a non-empty queue
   a_disp_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DISP_READ || state_ff == ST_DISP_SEND) |-> count_ff != '0)
      else $error("dispatch with empty queue");

   // Canned report index stays inside the loaded sequence
   a_script_idx: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> script_idx_ff < script_len_ff)
      else $error("report index past sequence");

   // Removal with mic present disarms the countdown
   a_remove_disarm: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && cmd_ff == CMD_REMOVE && mic_found_ff) |=> !armed_ff)
      else $error("countdown still armed after removal");

endmodule

`default_nettype wire
